// File: src/smr_pkg.sv
`timescale 1ns / 1ps

package smr_pkg;

	// longest pattern the window can hold
	localparam int PATTERN_MAX_DEF = 16;

	// configuration port
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_REG_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOWER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_UPPER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LENGTH = 2'd2;

	// words held by each side queue
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
	} out_item_t;

endpackage

// File: src/smr_fifo.sv
`timescale 1ns / 1ps

module smr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + CW'(1);
				end
				2'b01: begin
					cnt_q <= cnt_q - CW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// File: src/smr_engine.sv
`timescale 1ns / 1ps

module smr_engine
	import smr_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF,
	localparam int LW = $clog2(PATTERN_MAX + 1),
	localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [8*PATTERN_MAX-1:0] pattern,
	input  logic [LW-1:0]            pat_len,
	input  logic                     in_valid,
	input  in_item_t                 in_item,
	output logic                     in_take,
	input  logic                     out_space,
	output logic                     out_push,
	output out_item_t                out_item
);

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_LOOP = 2'd1;
	localparam logic [1:0] MODE_REV  = 2'd2;

	logic [1:0]    mode_q, mode_d;
	logic [7:0]    win_q [PATTERN_MAX];
	logic [7:0]    win_d [PATTERN_MAX];
	logic [LW-1:0] fill_q, fill_d;
	logic          last_q, last_d;
	logic [IW-1:0] idx_q, idx_d;

	logic [7:0]    cw [PATTERN_MAX];
	logic [7:0]    sh [PATTERN_MAX];
	logic [LW-1:0] cf;
	logic [LW-1:0] nf;
	logic          cl;
	logic          loop_ok;
	logic          hit;
	logic          emit;
	logic          go_rev;
	logic          cont;
	logic          step;
	logic          run_end;
	logic [IW-1:0] pidx;
	logic [7:0]    pbyte;

	always_comb begin
		// window as seen this cycle, with the new word appended when one is taken
		cw = win_q;
		cf = fill_q;
		cl = last_q;
		if (mode_q == MODE_IDLE) begin
			cw[fill_q[IW-1:0]] = in_item.in_byte;
			cf = fill_q + LW'(1);
			cl = in_item.in_last;
		end

		hit = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (LW'(i) < pat_len && cw[i] != pattern[8*i +: 8]) begin
				hit = 1'b0;
			end
		end

		for (int i = 0; i < PATTERN_MAX - 1; i++) begin
			sh[i] = cw[i+1];
		end
		sh[PATTERN_MAX-1] = '0;

		loop_ok = (cf >= pat_len);
		nf      = cf - LW'(1);
		go_rev  = loop_ok && hit && (pat_len != LW'(1));
		cont    = (nf >= pat_len) || (cl && nf != '0);
		emit    = (mode_q == MODE_REV) || loop_ok || (cl && cf != '0);

		// a hit window equals the pattern, so the reversed run reads the pattern
		pidx  = (mode_q == MODE_REV) ? idx_q : IW'(pat_len - LW'(1));
		pbyte = pattern[8*pidx +: 8];

		in_take = out_space && (mode_q == MODE_IDLE) && in_valid;
		step    = out_space && ((mode_q != MODE_IDLE) || in_valid);

		mode_d   = mode_q;
		win_d    = win_q;
		fill_d   = fill_q;
		last_d   = last_q;
		idx_d    = idx_q;
		out_push = 1'b0;
		run_end  = 1'b0;

		if (step) begin
			last_d = cl;
			if (emit) begin
				win_d    = sh;
				fill_d   = nf;
				out_push = 1'b1;
				if (mode_q == MODE_REV && idx_q != '0) begin
					mode_d = MODE_REV;
					idx_d  = idx_q - IW'(1);
				end else if (mode_q != MODE_REV && go_rev) begin
					mode_d = MODE_REV;
					idx_d  = IW'(pat_len - LW'(2));
				end else if (cont) begin
					mode_d = MODE_LOOP;
				end else begin
					mode_d  = MODE_IDLE;
					run_end = 1'b1;
				end
			end else begin
				win_d  = cw;
				fill_d = cf;
				mode_d = MODE_IDLE;
			end
		end

		out_item.out_byte   = ((mode_q == MODE_REV) || (loop_ok && hit)) ? pbyte : cw[0];
		out_item.run_last   = run_end;
		out_item.stream_end = run_end && cl;
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			fill_q <= '0;
			last_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			mode_q <= mode_d;
			fill_q <= fill_d;
			last_q <= last_d;
			idx_q  <= idx_d;
		end
	end

endmodule

// File: src/stream_match_reverse.sv
`timescale 1ns / 1ps

// Byte stream pattern reverser. Bytes pushed in come back out in order, except that each
// leftmost, non-overlapping occurrence of the configured pattern comes out reversed; bytes
// are held back until the window of pattern-length bytes is full, and a word with in_last
// set flushes the window. run_last marks the last result word caused by an input word,
// stream_end the last word of the stream. The window engine takes at most one input word
// per cycle, only while idle and with room in the result queue, and produces at most one
// result word per cycle, so plain text streams at one byte per cycle while not stalled;
// a match of L bytes holds the input while its reversed run is emitted, and a final flush
// holds it until the window is empty. Two-word queues on either side let input and output
// stall independently; accepted words and result words are each registered in their queue.
// Write the pattern registers only while no word is in flight.
module stream_match_reverse
	import smr_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	input  in_item_t             item,
	output logic                 full,
	input  logic                 pop,
	output out_item_t            result,
	output logic                 empty
);

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [CFG_W-1:0]     pat_lower_q;
	logic [CFG_W-1:0]     pat_upper_q;
	logic [LW-1:0]        pat_len_q;
	logic [LW-1:0]        len_new;
	logic [LEN_REG_W-1:0] len_raw;
	logic [2*CFG_W-1:0]   pat_all;

	logic      in_empty;
	in_item_t  in_head;
	logic      eng_take;
	logic      eng_push;
	out_item_t eng_item;
	logic      out_full;

	assign len_raw = cfg_data[LEN_REG_W-1:0];
	assign pat_all = {pat_upper_q, pat_lower_q};

	// out-of-range lengths clamp to the usable range
	always_comb begin
		if (len_raw == '0) begin
			len_new = LW'(1);
		end else if (32'(len_raw) > PATTERN_MAX) begin
			len_new = LW'(PATTERN_MAX);
		end else begin
			len_new = LW'(len_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lower_q <= '0;
			pat_upper_q <= '0;
			pat_len_q   <= LW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAT_LOWER: begin
					pat_lower_q <= cfg_data;
				end
				CFG_PAT_UPPER: begin
					pat_upper_q <= cfg_data;
				end
				CFG_PAT_LENGTH: begin
					pat_len_q <= len_new;
				end
				default: begin
				end
			endcase
		end
	end

	smr_fifo #(
		.WIDTH ($bits(in_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item),
		.full   (full),
		.pop    (eng_take),
		.rdata  (in_head),
		.empty  (in_empty)
	);

	smr_engine #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.pattern   (pat_all[8*PATTERN_MAX-1:0]),
		.pat_len   (pat_len_q),
		.in_valid  (!in_empty),
		.in_item   (in_head),
		.in_take   (eng_take),
		.out_space (!out_full),
		.out_push  (eng_push),
		.out_item  (eng_item)
	);

	smr_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (eng_push),
		.wdata  (eng_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		eng_push |-> !out_full)
		else $error("engine pushed a word into a full result queue");

	a_take_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		eng_take |-> !in_empty)
		else $error("engine took a word from an empty input queue");

	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !in_empty)
		else $error("accepted word missing from input queue");
`endif

endmodule
